// ===== design/qrv_pkg.sv =====
// ============================================================================
// qrv_pkg
// Shared widths, types and the CORDIC step table for the quaternion to
// rotation vector pipeline.
// ============================================================================
package qrv_pkg;

    localparam int OUT_FRAC_BITS = 16;               // fraction bits of rot_*

    localparam int IN_W      = 16;                   // quaternion word
    localparam int OUT_W     = 19;                   // rotation component
    localparam int SQ_W      = 2 * IN_W - 1;         // one square, x^2 <= 2^30
    localparam int SS_W      = 32;                   // x^2 + y^2 + z^2
    localparam int SQ_IN_W   = SS_W + 16;            // ss with 16 extra fraction bits
    localparam int RT_W      = SQ_IN_W / 2;          // root sfx
    localparam int REM_W     = RT_W + 3;             // root remainder
    localparam int CORDIC_STEPS = 32;
    localparam int ATAN_TAB  = 11;                   // table entries before 2^(32-i)
    localparam int CW        = 44;                   // CORDIC x / y
    localparam int AG_W      = 35;                   // CORDIC angle accumulator
    localparam int ANG_W     = AG_W + 1;             // doubled angle
    localparam int MAG_W     = AG_W;                 // |angle|
    localparam int DEN_W     = RT_W + 32 - OUT_FRAC_BITS;
    localparam int QW        = OUT_FRAC_BITS + 4;    // quotient bits
    localparam int PROD_W    = IN_W + MAG_W;
    localparam int NUM_W     = DEN_W + QW;           // rounded numerator
    localparam int LANE_LAT  = QW + 3;               // multiply, round, divide, saturate
    localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;

    typedef logic signed [IN_W-1:0]  comp_t;
    typedef logic signed [OUT_W-1:0] rot_t;

    localparam rot_t ROT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Side data that travels along with the root and CORDIC stages
    typedef struct packed {
        logic              zero;  // vector part is zero
        logic              wneg;  // scalar part negative
        logic [IN_W-1:0]   aw;    // |w|
        comp_t             x;
        comp_t             y;
        comp_t             z;
    } side_t;

    // atan(2^-i) in units of 2^-32 rad; 2^(32-i) beyond the table
    function automatic logic [AG_W-1:0] atan_step(input int i);
        logic [AG_W-1:0] t;
        case (i)
            0:       t = 35'd3373259426;
            1:       t = 35'd1991351318;
            2:       t = 35'd1052175346;
            3:       t = 35'd534100635;
            4:       t = 35'd268086748;
            5:       t = 35'd134174063;
            6:       t = 35'd67103403;
            7:       t = 35'd33553749;
            8:       t = 35'd16777131;
            9:       t = 35'd8388597;
            10:      t = 35'd4194303;
            default: t = AG_W'(64'd1 << (32 - i));
        endcase
        return t;
    endfunction

endpackage

// ===== design/qrv_in_if.sv =====
// ============================================================================
// qrv_in_if
// Input channel: one quaternion item per valid/ready handshake.
// ============================================================================
interface qrv_in_if import qrv_pkg::*; ();
    logic  valid;
    logic  ready;
    comp_t quat_w;
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

// ===== design/qrv_out_if.sv =====
// ============================================================================
// qrv_out_if
// Output channel: one rotation vector item per valid/ready handshake.
// ============================================================================
interface qrv_out_if import qrv_pkg::*; ();
    logic valid;
    logic ready;
    rot_t rot_x;
    rot_t rot_y;
    rot_t rot_z;

    modport source (output valid, output rot_x, output rot_y, output rot_z,
                    input ready);
    modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                    output ready);
endinterface

// ===== design/qrv_div_lane.sv =====
// ============================================================================
// qrv_div_lane
// One output component: |c|*|angle|, rounding offset, radix-2 restoring
// divide by the scaled length, saturate and sign.
// ============================================================================
module qrv_div_lane import qrv_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  comp_t            comp,
    input  logic             ang_neg,
    input  logic [MAG_W-1:0] mag,
    input  logic [DEN_W-1:0] den,
    input  logic             zero,
    output rot_t             rot
);

    // multiply stage
    logic [IN_W-1:0]   mc_next;
    logic [PROD_W-1:0] prod_reg;
    logic [DEN_W-1:0]  pden_reg;
    logic              pneg_reg;
    logic              pzero_reg;

    // rounding stage
    logic [NUM_W-1:0]  numr_next;
    logic [NUM_W-1:0]  numr_reg;
    logic [DEN_W-1:0]  rden_reg;
    logic              rneg_reg;
    logic              rzero_reg;

    // divide stages, index 0 is the stage input
    logic [DEN_W-1:0]  rem_src  [0:QW];
    logic [QW-1:0]     lo_src   [0:QW];
    logic [QW-1:0]     q_src    [0:QW];
    logic [DEN_W-1:0]  den_src  [0:QW];
    logic              neg_src  [0:QW];
    logic              zero_src [0:QW];

    logic [QW-1:0]     qsat_next;
    rot_t              rot_next;
    rot_t              rot_reg;

    assign mc_next = comp[IN_W-1] ? IN_W'(-comp) : IN_W'(comp);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= PROD_W'(mc_next) * PROD_W'(mag);
            pden_reg  <= den;
            pneg_reg  <= comp[IN_W-1] ^ ang_neg;
            pzero_reg <= zero;
        end
    end

    assign numr_next = (NUM_W'(prod_reg) << 8) + NUM_W'(pden_reg >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numr_reg  <= numr_next;
            rden_reg  <= pden_reg;
            rneg_reg  <= pneg_reg;
            rzero_reg <= pzero_reg;
        end
    end

    assign rem_src[0]  = numr_reg[NUM_W-1:QW];
    assign lo_src[0]   = numr_reg[QW-1:0];
    assign q_src[0]    = '0;
    assign den_src[0]  = rden_reg;
    assign neg_src[0]  = rneg_reg;
    assign zero_src[0] = rzero_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [DEN_W:0]   t_next;
        logic [DEN_W-1:0] rem_next;
        logic [QW-1:0]    q_next;
        logic [DEN_W-1:0] rem_reg;
        logic [QW-1:0]    lo_reg;
        logic [QW-1:0]    q_reg;
        logic [DEN_W-1:0] den_reg;
        logic             neg_reg;
        logic             zero_reg;

        always_comb
        begin
            t_next = {rem_src[k], lo_src[k][QW-1]};
            if (t_next >= {1'b0, den_src[k]})
            begin
                rem_next = DEN_W'(t_next - {1'b0, den_src[k]});
                q_next   = {q_src[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = t_next[DEN_W-1:0];
                q_next   = {q_src[k][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                lo_reg   <= lo_src[k] << 1;
                q_reg    <= q_next;
                den_reg  <= den_src[k];
                neg_reg  <= neg_src[k];
                zero_reg <= zero_src[k];
            end
        end

        assign rem_src[k+1]  = rem_reg;
        assign lo_src[k+1]   = lo_reg;
        assign q_src[k+1]    = q_reg;
        assign den_src[k+1]  = den_reg;
        assign neg_src[k+1]  = neg_reg;
        assign zero_src[k+1] = zero_reg;
    end

    always_comb
    begin
        qsat_next = (q_src[QW] > QW'(OUT_MAX)) ? QW'(OUT_MAX) : q_src[QW];
        if (zero_src[QW])
            rot_next = '0;
        else if (neg_src[QW])
            rot_next = -rot_t'(qsat_next);
        else
            rot_next = rot_t'(qsat_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rot_reg <= rot_next;
    end

    assign rot = rot_reg;

endmodule

// ===== design/quaternion_to_rotation_vector.sv =====
// ============================================================================
// quaternion_to_rotation_vector
// Log map of a joint quaternion: rotation vector = (x,y,z) * angle / |(x,y,z)|
// with angle = 2*atan2(s, |w|), negated for w < 0.
// ============================================================================
//
//  channel  dir  fields                          unit
//  -------  ---  ------------------------------  -------------------------
//  in_ch    in   quat_w, quat_x, quat_y, quat_z  signed 16b, 0.0001
//  out_ch   out  rot_x, rot_y, rot_z             signed 19b, rad * 2^16
//
//  One item enters per cycle unless the output stalls; stages: input, squares, sum,
//  root (24 digit stages), CORDIC setup, CORDIC (32 vectoring stages), angle,
//  then per lane multiply, round, divide (QW = OUT_FRAC_BITS + 4 quotient stages), saturate.
//  All stages share one advance enable: the pipe moves when the output
//  register is empty or being taken, so a stall freezes every stage in place.
//  Reset clears only the valid bits; data registers are left as they are.
//
module quaternion_to_rotation_vector import qrv_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    qrv_in_if.sink    in_ch,
    qrv_out_if.source out_ch
);

    // pipeline map
    localparam int SQRT_FIRST = 3;
    localparam int CRD_INIT   = SQRT_FIRST + RT_W;
    localparam int CRD_LAST   = CRD_INIT + CORDIC_STEPS;
    localparam int ANG_STG    = CRD_LAST + 1;
    localparam int LAT        = ANG_STG + 1 + LANE_LAT;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    // advance when the output slot is free or being emptied
    assign en          = !vld_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = en;
    assign vld_next    = {vld_reg[LAT-2:0], in_ch.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // ---- stage 0: input register
    comp_t w_reg, x_reg, y_reg, z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg <= in_ch.quat_w;
            x_reg <= in_ch.quat_x;
            y_reg <= in_ch.quat_y;
            z_reg <= in_ch.quat_z;
        end
    end

    // ---- stage 1: squares, zero test, |w|
    logic signed [2*IN_W-1:0] px_next, py_next, pz_next;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    side_t                    side1_next, side1_reg;

    assign px_next = x_reg * x_reg;
    assign py_next = y_reg * y_reg;
    assign pz_next = z_reg * z_reg;

    always_comb
    begin
        side1_next.zero = (x_reg == '0) && (y_reg == '0) && (z_reg == '0);
        side1_next.wneg = w_reg[IN_W-1];
        side1_next.aw   = w_reg[IN_W-1] ? IN_W'(-w_reg) : IN_W'(w_reg);
        side1_next.x    = x_reg;
        side1_next.y    = y_reg;
        side1_next.z    = z_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= px_next[SQ_W-1:0];
            sqy_reg   <= py_next[SQ_W-1:0];
            sqz_reg   <= pz_next[SQ_W-1:0];
            side1_reg <= side1_next;
        end
    end

    // ---- stage 2: sum of squares
    logic [SS_W-1:0] ss_next, ss_reg;
    side_t           side2_reg;

    assign ss_next = SS_W'(sqx_reg) + SS_W'(sqy_reg) + SS_W'(sqz_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg    <= ss_next;
            side2_reg <= side1_reg;
        end
    end

    // ---- root stages: sfx = floor(sqrt(ss * 2^16)), two radicand bits a stage
    logic [REM_W-1:0]   rem_src  [0:RT_W];
    logic [RT_W-1:0]    root_src [0:RT_W];
    logic [SQ_IN_W-1:0] rad_src  [0:RT_W];
    side_t              sside_src[0:RT_W];

    assign rem_src[0]   = '0;
    assign root_src[0]  = '0;
    assign rad_src[0]   = {ss_reg, 16'b0};
    assign sside_src[0] = side2_reg;

    for (genvar k = 0; k < RT_W; k++)
    begin : g_sqrt
        logic [REM_W-1:0]   t_next;
        logic [REM_W-1:0]   trial_next;
        logic [REM_W-1:0]   rem_next;
        logic [RT_W-1:0]    root_next;
        logic [REM_W-1:0]   rem_reg;
        logic [RT_W-1:0]    root_reg;
        logic [SQ_IN_W-1:0] rad_reg;
        side_t              side_reg;

        always_comb
        begin
            t_next     = {rem_src[k][REM_W-3:0], rad_src[k][SQ_IN_W-1 -: 2]};
            trial_next = REM_W'({root_src[k], 2'b01});
            if (t_next >= trial_next)
            begin
                rem_next  = t_next - trial_next;
                root_next = {root_src[k][RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = t_next;
                root_next = {root_src[k][RT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= rad_src[k] << 2;
                side_reg <= sside_src[k];
            end
        end

        assign rem_src[k+1]   = rem_reg;
        assign root_src[k+1]  = root_reg;
        assign rad_src[k+1]   = rad_reg;
        assign sside_src[k+1] = side_reg;
    end

    // ---- CORDIC setup: (|w| * 2^24, sfx * 2^16)
    logic signed [CW-1:0]   cx_src   [0:CORDIC_STEPS];
    logic signed [CW-1:0]   cy_src   [0:CORDIC_STEPS];
    logic signed [AG_W-1:0] ang_src  [0:CORDIC_STEPS];
    logic [RT_W-1:0]        sfx_src  [0:CORDIC_STEPS];
    side_t                  cside_src[0:CORDIC_STEPS];

    logic signed [CW-1:0] cx0_reg, cy0_reg;
    logic [RT_W-1:0]      sfx0_reg;
    side_t                cside0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx0_reg    <= $signed(CW'({sside_src[RT_W].aw, 24'b0}));
            cy0_reg    <= $signed(CW'({root_src[RT_W], 16'b0}));
            sfx0_reg   <= root_src[RT_W];
            cside0_reg <= sside_src[RT_W];
        end
    end

    assign cx_src[0]    = cx0_reg;
    assign cy_src[0]    = cy0_reg;
    assign ang_src[0]   = '0;
    assign sfx_src[0]   = sfx0_reg;
    assign cside_src[0] = cside0_reg;

    // ---- CORDIC vectoring, one micro-rotation a stage
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        localparam logic signed [AG_W-1:0] STEP = $signed(atan_step(k));

        logic signed [CW-1:0]   dx_next, dy_next;
        logic signed [CW-1:0]   cx_next, cy_next;
        logic signed [AG_W-1:0] ang_next;
        logic signed [CW-1:0]   cx_reg, cy_reg;
        logic signed [AG_W-1:0] ang_reg;
        logic [RT_W-1:0]        sfx_reg;
        side_t                  side_reg;

        always_comb
        begin
            dx_next = cy_src[k] >>> k;
            dy_next = cx_src[k] >>> k;
            if (cy_src[k] > 0)
            begin
                cx_next  = cx_src[k] + dx_next;
                cy_next  = cy_src[k] - dy_next;
                ang_next = ang_src[k] + STEP;
            end
            else
            begin
                cx_next  = cx_src[k] - dx_next;
                cy_next  = cy_src[k] + dy_next;
                ang_next = ang_src[k] - STEP;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg   <= cx_next;
                cy_reg   <= cy_next;
                ang_reg  <= ang_next;
                sfx_reg  <= sfx_src[k];
                side_reg <= cside_src[k];
            end
        end

        assign cx_src[k+1]    = cx_reg;
        assign cy_src[k+1]    = cy_reg;
        assign ang_src[k+1]   = ang_reg;
        assign sfx_src[k+1]   = sfx_reg;
        assign cside_src[k+1] = side_reg;
    end

    // ---- angle stage: double, apply w sign, split into sign and magnitude
    logic signed [ANG_W-1:0] a2_next;
    logic [MAG_W-1:0]        mag_next, mag_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    aneg_reg;
    side_t                   aside_reg;

    always_comb
    begin
        a2_next = ANG_W'(ang_src[CORDIC_STEPS]) <<< 1;
        if (cside_src[CORDIC_STEPS].wneg)
            a2_next = -a2_next;
        mag_next = a2_next[ANG_W-1] ? MAG_W'(-a2_next) : MAG_W'(a2_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            aneg_reg  <= a2_next[ANG_W-1];
            den_reg   <= DEN_W'({sfx_src[CORDIC_STEPS], (32 - OUT_FRAC_BITS)'(0)});
            aside_reg <= cside_src[CORDIC_STEPS];
        end
    end

    // ---- per-component scale and divide
    qrv_div_lane u_lane_x (
        .clk     (clk),
        .en      (en),
        .comp    (aside_reg.x),
        .ang_neg (aneg_reg),
        .mag     (mag_reg),
        .den     (den_reg),
        .zero    (aside_reg.zero),
        .rot     (out_ch.rot_x)
    );

    qrv_div_lane u_lane_y (
        .clk     (clk),
        .en      (en),
        .comp    (aside_reg.y),
        .ang_neg (aneg_reg),
        .mag     (mag_reg),
        .den     (den_reg),
        .zero    (aside_reg.zero),
        .rot     (out_ch.rot_y)
    );

    qrv_div_lane u_lane_z (
        .clk     (clk),
        .en      (en),
        .comp    (aside_reg.z),
        .ang_neg (aneg_reg),
        .mag     (mag_reg),
        .den     (den_reg),
        .zero    (aside_reg.zero),
        .rot     (out_ch.rot_z)
    );

    assign out_ch.valid = vld_reg[LAT-1];

    // ---- checks
    // input is held off only by a full, stalled output register
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
        else $error("input stalled without an output stall");

    // vectoring keeps x in the right half plane
    a_cordic_x: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[CRD_LAST] |-> !cx_src[CORDIC_STEPS][CW-1])
        else $error("CORDIC x went negative");

    // saturation never yields the most negative code
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.rot_x != ROT_MIN) && (out_ch.rot_y != ROT_MIN)
                         && (out_ch.rot_z != ROT_MIN))
        else $error("rotation component out of range");

endmodule
